>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the maximal ones rectangle block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define MOR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true out of reset
`define MOR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/mor_pkg.sv
// Shared constants and types of the maximal ones rectangle block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mor_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CNT_W       = $clog2(MAX_COLS + 1);
  localparam int HGT_W       = $clog2(MAX_ROWS + 1);
  localparam int CFG_W       = 7;
  localparam int AREA_W      = 13;
  localparam int AREA_MAX    = (1 << AREA_W) - 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((AREA_W + 7) / 8) * 8;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [HGT_W-1:0]  hgt_t;
  typedef logic [AREA_W-1:0] area_t;

  // Height memory read request
  typedef struct packed {
    logic en;
    col_t addr;
  } hrd_req_t;

  // Control from the cell sequencer to the row evaluator
  typedef struct packed {
    logic start;
    logic clear_best;
    cnt_t n;
  } eval_ctl_t;

  // Status back from the row evaluator
  typedef struct packed {
    logic  done;
    area_t best;
  } eval_sts_t;

endpackage

>>> rtl/mor_height_store.sv
// Column height memory with per-column valid bits; an unwritten column reads zero.
// Depends on mor_pkg.
`timescale 1ns / 1ps

module mor_height_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mor_pkg::hrd_req_t rd_i,
  input  logic              wr_en_i,
  input  mor_pkg::col_t     wr_addr_i,
  input  mor_pkg::hgt_t     wr_data_i,
  input  logic              clr_all_i,
  output mor_pkg::hgt_t     rd_data_o
);
  import mor_pkg::*;

  hgt_t                mem [MAX_COLS];
  logic [MAX_COLS-1:0] valid_q;
  hgt_t                rd_q;
  logic                rd_vld_q;

  // valid bits: cleared at reset and at end of matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_all_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= valid_q[rd_i.addr];
      end
    end
  end

  // storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_i.en) begin
      rd_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/mor_hist_eval.sv
// Row evaluator: largest rectangle under the height histogram with a
// monotonic stack kept in memory (top entry in registers). Depends on mor_pkg.
`timescale 1ns / 1ps

module mor_hist_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mor_pkg::eval_ctl_t ctl_i,
  output mor_pkg::hrd_req_t  hrd_o,
  input  mor_pkg::hgt_t      hgt_i,
  output mor_pkg::eval_sts_t sts_o
);
  import mor_pkg::*;

  localparam int PROD_W = HGT_W + CNT_W;
  typedef logic [PROD_W-1:0] prod_t;

  // stack entry: bar height and the leftmost column it spans
  typedef struct packed {
    hgt_t h;
    col_t left;
  } stk_ent_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_RD,
    E_POP,
    E_LOAD
  } eval_state_e;

  eval_state_e state_q;
  cnt_t        n_q, i_q, depth_q;
  col_t        left_q;
  stk_ent_t    top_q;
  area_t       best_q;
  logic        done_q;

  stk_ent_t    stk_mem [MAX_COLS];
  stk_ent_t    stk_rd_q;

  logic        lt_n, pop, stk_we, stk_re;
  hgt_t        cur;
  cnt_t        i_nxt, dm1, dm2, bar_w;
  prod_t       prod;
  area_t       area_sat;

  // pop decision and area of the bar leaving the stack
  always_comb begin
    lt_n     = i_q < n_q;
    cur      = lt_n ? hgt_i : '0;
    pop      = (depth_q != '0) && (top_q.h >= cur);
    i_nxt    = i_q + cnt_t'(1);
    dm1      = depth_q - cnt_t'(1);
    dm2      = depth_q - cnt_t'(2);
    bar_w    = i_q - cnt_t'(top_q.left);
    prod     = prod_t'(top_q.h) * prod_t'(bar_w);
    area_sat = (prod > prod_t'(AREA_MAX)) ? area_t'(AREA_MAX) : area_t'(prod);
    stk_we   = (state_q == E_POP) && !pop && lt_n && (depth_q != '0);
    stk_re   = (state_q == E_POP) && pop && (depth_q > cnt_t'(1));
  end

  // height reads: column 0 at start, next column on each push
  always_comb begin
    hrd_o.en   = 1'b0;
    hrd_o.addr = i_nxt[COL_W-1:0];
    if (state_q == E_RD) begin
      hrd_o.en   = 1'b1;
      hrd_o.addr = i_q[COL_W-1:0];
    end else if ((state_q == E_POP) && !pop && lt_n && (i_nxt < n_q)) begin
      hrd_o.en = 1'b1;
    end
  end

  // stack memory: old top spills on push, entry below reloads on pop
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[dm1[COL_W-1:0]] <= top_q;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[dm2[COL_W-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      depth_q <= '0;
      left_q  <= '0;
      top_q   <= '0;
      best_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (ctl_i.clear_best) begin
            best_q <= '0;
          end
          if (ctl_i.start) begin
            n_q     <= ctl_i.n;
            i_q     <= '0;
            depth_q <= '0;
            left_q  <= '0;
            state_q <= E_RD;
          end
        end
        E_RD: begin
          state_q <= E_POP;
        end
        E_POP: begin
          if (pop) begin
            if (area_sat > best_q) begin
              best_q <= area_sat;
            end
            depth_q <= dm1;
            left_q  <= top_q.left;
            if (depth_q > cnt_t'(1)) begin
              state_q <= E_LOAD;
            end
          end else if (lt_n) begin
            top_q.h    <= cur;
            top_q.left <= left_q;
            depth_q    <= depth_q + cnt_t'(1);
            i_q        <= i_nxt;
            left_q     <= i_nxt[COL_W-1:0];
          end else begin
            // closing bar handled and stack empty
            done_q  <= 1'b1;
            state_q <= E_IDLE;
          end
        end
        E_LOAD: begin
          top_q   <= stk_rd_q;
          state_q <= E_POP;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.best = best_q;

endmodule

>>> rtl/maximal_ones_rectangle.sv
// Maximal all-ones rectangle of a streamed binary matrix. Each accepted cell
// goes through a height read, then a write-back of the updated column height.
// At a row end of n columns the evaluator runs, during which no cell is taken;
// every column is pushed and popped once (n pops), and each pop that leaves
// entries below reloads the new top through a registered stack memory read.
// The result of the whole matrix leaves on the master stream after the cell
// marked tlast; the output register lets the next matrix start while it waits.
// Depends on mor_pkg, mor_height_store, mor_hist_eval and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module maximal_ones_rectangle (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: row_width
  input  logic                                 cfg_we_i,
  input  logic [mor_pkg::CFG_W-1:0]            cfg_wdata_i,
  // cell stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mor_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [0] cell_req, rest zero
  input  logic                                 s_axis_tlast,  // last cell of matrix
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mor_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // [12:0] max_area, rest zero
);
  import mor_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_EVAL,
    S_OUT
  } top_state_e;

  top_state_e        state_q;
  logic [CFG_W-1:0]  row_width_q;
  logic              cell_q, last_q;
  col_t              col_q;
  logic              out_valid_q;
  area_t             out_data_q;

  cnt_t              width_eff, col_inc;
  logic              accept, row_end, out_free;
  hgt_t              hgt_rd, hgt_new;
  hrd_req_t          hrd, eval_hrd;
  eval_ctl_t         eval_ctl;
  eval_sts_t         eval_sts;

  // effective row width: zero counts as one, clamp to the column count
  always_comb begin
    if (row_width_q == '0) begin
      width_eff = cnt_t'(1);
    end else if (int'(row_width_q) > MAX_COLS) begin
      width_eff = cnt_t'(MAX_COLS);
    end else begin
      width_eff = cnt_t'(row_width_q);
    end
  end

  // handshake and row end
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign col_inc       = cnt_t'(col_q) + cnt_t'(1);
  assign row_end       = (col_inc >= width_eff) || last_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // height update: set cell adds one up to MAX_ROWS, clear cell zeroes
  always_comb begin
    if (!cell_q) begin
      hgt_new = '0;
    end else if (hgt_rd < hgt_t'(MAX_ROWS)) begin
      hgt_new = hgt_rd + hgt_t'(1);
    end else begin
      hgt_new = hgt_rd;
    end
  end

  // height read port: cell sequencer on a beat, evaluator otherwise
  always_comb begin
    if (accept) begin
      hrd.en   = 1'b1;
      hrd.addr = col_q;
    end else begin
      hrd = eval_hrd;
    end
  end

  assign eval_ctl.start      = (state_q == S_UPD) && row_end;
  assign eval_ctl.n          = col_inc;
  assign eval_ctl.clear_best = (state_q == S_OUT) && out_free;

  mor_height_store u_height (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (hrd),
    .wr_en_i   (state_q == S_UPD),
    .wr_addr_i (col_q),
    .wr_data_i (hgt_new),
    .clr_all_i (eval_ctl.clear_best),
    .rd_data_o (hgt_rd)
  );

  mor_hist_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (eval_ctl),
    .hrd_o  (eval_hrd),
    .hgt_i  (hgt_rd),
    .sts_o  (eval_sts)
  );

  // cell sequencer, config register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_width_q <= CFG_W'(MAX_COLS);
      cell_q      <= 1'b0;
      last_q      <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      // output state reloads the register itself
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cell_q  <= s_axis_tdata[0];
            last_q  <= s_axis_tlast;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (row_end) begin
            col_q   <= '0;
            state_q <= S_EVAL;
          end else begin
            col_q   <= col_inc[COL_W-1:0];
            state_q <= S_IDLE;
          end
        end
        S_EVAL: begin
          if (eval_sts.done) begin
            state_q <= last_q ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= eval_sts.best;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

  // checks on the sequencing
  `MOR_ASSERT(a_result_from_out, $rose(m_axis_tvalid) |-> $past(state_q == S_OUT), "result beat not from output state")
  `MOR_NEVER(a_done_outside_eval, eval_sts.done && (state_q != S_EVAL), "row evaluation finished while not waited for")
  `MOR_ASSERT(a_row_restart, $rose(m_axis_tvalid) |-> (col_q == '0), "column count not cleared at end of matrix")

endmodule
